// ----- rtl/core/d2q_pkg.sv -----
`default_nettype none
package d2q_pkg;

   localparam int NDir = 9;
   localparam int QW = 32;
   localparam int CsrIdxW = 8;
   localparam int CsrDataW = 32;
   localparam int OmegaW = 26;
   localparam int WeightW = 25;
   localparam int FracW = 24;

   localparam logic [OmegaW-1:0] OmegaReset = 26'd16777216;
   localparam logic [WeightW-1:0] WeightCenterReset = 25'd7456540;
   localparam logic [WeightW-1:0] WeightAxisReset = 25'd1864135;
   localparam logic [WeightW-1:0] WeightDiagReset = 25'd466034;

   localparam logic [CsrIdxW-1:0] RegOmega = 8'd0;
   localparam logic [CsrIdxW-1:0] RegWeightCenter = 8'd1;
   localparam logic [CsrIdxW-1:0] RegWeightAxis = 8'd2;
   localparam logic [CsrIdxW-1:0] RegWeightDiag = 8'd3;

   // pipeline stage numbers counted from the input register
   localparam int StMom = 1;
   localparam int DivLat = 34;
   localparam int StDivOut = StMom + DivLat;
   localparam int StT1 = StDivOut + 1;
   localparam int StT2 = StT1 + 1;
   localparam int LaneLat = 7;
   localparam int StOut = StT2 + LaneLat;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [1:0] dir_type;

   typedef enum logic [1:0] {
      WCLS_CENTER = 2'd0,
      WCLS_AXIS   = 2'd1,
      WCLS_DIAG   = 2'd2
   } wcls_type;

   localparam dir_type DirCx [NDir] = '{2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                        2'sd0, -2'sd1, -2'sd1, -2'sd1};
   localparam dir_type DirCy [NDir] = '{2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                        2'sd1, 2'sd1, 2'sd0, -2'sd1};
   localparam wcls_type DirCls [NDir] = '{WCLS_CENTER, WCLS_AXIS, WCLS_DIAG,
                                          WCLS_AXIS, WCLS_DIAG, WCLS_AXIS,
                                          WCLS_DIAG, WCLS_AXIS, WCLS_DIAG};

   function automatic q_type sat32(input logic signed [63:0] x);
      q_type r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/d2q_divider.sv -----
`default_nettype none
module d2q_divider (
   input  wire logic                 clock,
   input  wire logic                 ce,
   input  wire logic signed [35:0]   num,
   input  wire d2q_pkg::q_type       den,
   output d2q_pkg::q_type            quo
);
   import d2q_pkg::*;

   // quotient of (num * 2^24) / den, toward zero, one quotient bit per stage
   typedef struct packed {
      logic [30:0] rem;
      logic [7:0]  lo;
      logic [31:0] q;
      logic [30:0] den;
      logic        sign;
      logic        ovf;
      logic        pos;
   } dstage_type;

   dstage_type stg_ff [0:32];
   dstage_type pre_in;
   logic [35:0] mag;
   q_type quo_ff, quo_in;

   always_comb begin
      mag = num[35] ? 36'(-num) : 36'(num);
      pre_in.sign = num[35];
      pre_in.pos = (den > 32'sd0);
      pre_in.den = den[30:0];
      pre_in.ovf = {3'b000, mag} >= {den[30:0], 8'b0};
      pre_in.rem = {3'b000, mag[35:8]};
      pre_in.lo = mag[7:0];
      pre_in.q = '0;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         stg_ff[0] <= pre_in;
      end
   end

   for (genvar k = 1; k <= 32; k++) begin : g_bit
      dstage_type nx;
      logic [31:0] trial;
      logic bin, ge;
      always_comb begin
         bin = stg_ff[k-1].lo[7];
         trial = {stg_ff[k-1].rem, bin};
         ge = trial >= {1'b0, stg_ff[k-1].den};
         nx = stg_ff[k-1];
         nx.lo = {stg_ff[k-1].lo[6:0], 1'b0};
         nx.rem = ge ? 31'(trial - {1'b0, stg_ff[k-1].den}) : trial[30:0];
         nx.q[32-k] = ge;
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            stg_ff[k] <= nx;
         end
      end
   end

   always_comb begin
      if (!stg_ff[32].pos) begin
         quo_in = '0;
      end else if (stg_ff[32].ovf) begin
         quo_in = stg_ff[32].sign ? 32'sh80000000 : 32'sh7fffffff;
      end else if (stg_ff[32].sign) begin
         quo_in = sat32(-$signed({32'b0, stg_ff[32].q}));
      end else begin
         quo_in = sat32($signed({32'b0, stg_ff[32].q}));
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/core/d2q_lane.sv -----
`default_nettype none
module d2q_lane (
   input  wire logic                        clock,
   input  wire logic                        ce,
   input  wire d2q_pkg::dir_type            cx,
   input  wire d2q_pkg::dir_type            cy,
   input  wire d2q_pkg::q_type              ux,
   input  wire d2q_pkg::q_type              uy,
   input  wire logic [40:0]                 last,
   input  wire d2q_pkg::q_type              wr,
   input  wire d2q_pkg::q_type              f,
   input  wire logic [d2q_pkg::OmegaW-1:0]  omega,
   output d2q_pkg::q_type                   r
);
   import d2q_pkg::*;

   q_type e1_ff, e2_ff, wr1_ff, wr2_ff, wr3_ff, poly3_ff, feq5_ff, r7_ff;
   q_type f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   logic [40:0] last1_ff, last2_ff;
   logic [38:0] s2_ff;
   logic signed [63:0] prod4_ff;
   logic signed [58:0] a6_ff, b6_ff;
   logic signed [33:0] tx, ty;
   logic signed [63:0] esq;
   logic signed [43:0] poly_w;
   logic signed [26:0] keep, om_s;
   logic signed [59:0] acc;

   always_comb begin
      tx = (cx == 2'sd1) ? 34'(ux) : ((cx == -2'sd1) ? -34'(ux) : 34'sd0);
      ty = (cy == 2'sd1) ? 34'(uy) : ((cy == -2'sd1) ? -34'(uy) : 34'sd0);
      esq = e1_ff * e1_ff;
      poly_w = 44'sd16777216 + 44'(e2_ff) * 44'sd3
             + $signed({3'b000, s2_ff, 2'b00})
             + $signed({6'b0, s2_ff[38:1]})
             - $signed({3'b000, last2_ff});
      om_s = $signed({1'b0, omega});
      keep = 27'sd16777216 - om_s;
      acc = 60'(a6_ff) + 60'(b6_ff);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         e1_ff <= sat32(64'(tx + ty));
         last1_ff <= last;
         wr1_ff <= wr;
         f1_ff <= f;
         e2_ff <= e1_ff;
         s2_ff <= esq[62:24];
         last2_ff <= last1_ff;
         wr2_ff <= wr1_ff;
         f2_ff <= f1_ff;
         poly3_ff <= sat32(64'(poly_w));
         wr3_ff <= wr2_ff;
         f3_ff <= f2_ff;
         prod4_ff <= wr3_ff * poly3_ff;
         f4_ff <= f3_ff;
         feq5_ff <= sat32(64'(prod4_ff >>> FracW));
         f5_ff <= f4_ff;
         a6_ff <= 59'(f5_ff) * 59'(keep);
         b6_ff <= 59'(feq5_ff) * 59'(om_s);
         r7_ff <= sat32(64'(acc >>> FracW));
      end
   end

   assign r = r7_ff;

endmodule
`default_nettype wire

// ----- rtl/core/d2q9_bgk_collision.sv -----
// D2Q9 BGK collision, signed Q8.24. One node (nine distributions) is taken per
// clock while the output is not stalled. The pipeline is made up mostly of the
// velocity divider, which resolves one quotient bit per stage over 32 stages,
// followed by nine direction lanes of seven stages each. A stall on the result
// side holds the whole pipeline. Configuration writes take effect at once and
// are meant to be made while the pipeline is empty.
`default_nettype none
module d2q9_bgk_collision (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   // f_center, f_north, f_north_east, f_east, f_south_east, f_south,
   // f_south_west, f_west, f_north_west; 32 bits each from bit 0
   input  wire logic [287:0]   req_tdata,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   // out_center .. out_north_west, node_density, velocity_x, velocity_y;
   // 32 bits each from bit 0
   output logic [383:0]        rsp_tdata,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [7:0]     csr_index,
   input  wire logic [31:0]    csr_data
);
   import d2q_pkg::*;

   typedef struct packed {
      logic [NDir-1:0][QW-1:0] f;
      logic [QW-1:0]           rho;
   } side_type;

   logic ce;
   logic [StOut:0] vld_ff;
   side_type side_ff [0:StOut];
   side_type side0_in;
   logic signed [35:0] jx_ff, jy_ff, jx_in, jy_in;
   logic signed [35:0] sum_in;
   q_type ux_div, uy_div;
   q_type ux_ff [StDivOut+1:StOut];
   q_type uy_ff [StDivOut+1:StOut];
   logic [38:0] sqx_ff, sqy_ff;
   logic signed [63:0] sqx_p, sqy_p;
   logic signed [57:0] wprod_ff [3];
   q_type wr_ff [3];
   logic [40:0] last_ff;
   logic [39:0] usq;
   logic [OmegaW-1:0] omega_ff;
   logic [WeightW-1:0] wc_ff, wa_ff, wd_ff;
   logic [WeightW-1:0] wsel [3];
   q_type lane_r [NDir];

   assign ce = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = vld_ff[StOut];

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff <= OmegaReset;
         wc_ff <= WeightCenterReset;
         wa_ff <= WeightAxisReset;
         wd_ff <= WeightDiagReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegOmega:        omega_ff <= csr_data[OmegaW-1:0];
            RegWeightCenter: wc_ff <= csr_data[WeightW-1:0];
            RegWeightAxis:   wa_ff <= csr_data[WeightW-1:0];
            RegWeightDiag:   wd_ff <= csr_data[WeightW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[StOut-1:0], req_tvalid};
      end
   end

   // moments
   always_comb begin
      side0_in = side_ff[0];
      sum_in = '0;
      jx_in = '0;
      jy_in = '0;
      for (int i = 0; i < NDir; i++) begin
         sum_in = sum_in + 36'($signed(side_ff[0].f[i]));
         if (DirCx[i] == 2'sd1) jx_in = jx_in + 36'($signed(side_ff[0].f[i]));
         if (DirCx[i] == -2'sd1) jx_in = jx_in - 36'($signed(side_ff[0].f[i]));
         if (DirCy[i] == 2'sd1) jy_in = jy_in + 36'($signed(side_ff[0].f[i]));
         if (DirCy[i] == -2'sd1) jy_in = jy_in - 36'($signed(side_ff[0].f[i]));
      end
      side0_in.rho = sat32(64'(sum_in));
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[0].f <= req_tdata;
         side_ff[0].rho <= '0;
         side_ff[StMom] <= side0_in;
         jx_ff <= jx_in;
         jy_ff <= jy_in;
         for (int k = StMom + 1; k <= StOut; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   d2q_divider u_div_x (
      .clock (clock), .ce (ce), .num (jx_ff), .den (side_ff[StMom].rho),
      .quo (ux_div)
   );

   d2q_divider u_div_y (
      .clock (clock), .ce (ce), .num (jy_ff), .den (side_ff[StMom].rho),
      .quo (uy_div)
   );

   assign wsel[0] = wc_ff;
   assign wsel[1] = wa_ff;
   assign wsel[2] = wd_ff;
   assign sqx_p = ux_div * ux_div;
   assign sqy_p = uy_div * uy_div;
   assign usq = 40'(sqx_ff) + 40'(sqy_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         ux_ff[StDivOut+1] <= ux_div;
         uy_ff[StDivOut+1] <= uy_div;
         for (int k = StDivOut + 2; k <= StOut; k++) begin
            ux_ff[k] <= ux_ff[k-1];
            uy_ff[k] <= uy_ff[k-1];
         end
         sqx_ff <= sqx_p[62:24];
         sqy_ff <= sqy_p[62:24];
         for (int c = 0; c < 3; c++) begin
            wprod_ff[c] <= $signed({1'b0, wsel[c]}) * $signed(side_ff[StDivOut].rho);
            wr_ff[c] <= sat32(64'(wprod_ff[c] >>> FracW));
         end
         last_ff <= 41'(usq) + 41'(usq[39:1]);
      end
   end

   for (genvar i = 0; i < NDir; i++) begin : g_lane
      d2q_lane u_lane (
         .clock (clock),
         .ce    (ce),
         .cx    (DirCx[i]),
         .cy    (DirCy[i]),
         .ux    (ux_ff[StT2]),
         .uy    (uy_ff[StT2]),
         .last  (last_ff),
         .wr    (wr_ff[DirCls[i]]),
         .f     (side_ff[StT2].f[i]),
         .omega (omega_ff),
         .r     (lane_r[i])
      );
      assign rsp_tdata[i*QW +: QW] = lane_r[i];
   end

   assign rsp_tdata[NDir*QW +: QW] = side_ff[StOut].rho;
   assign rsp_tdata[(NDir+1)*QW +: QW] = ux_ff[StOut];
   assign rsp_tdata[(NDir+2)*QW +: QW] = uy_ff[StOut];

`ifndef ASSERT_OFF
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_zero_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ($signed(rsp_tdata[319:288]) <= 32'sd0)
      |-> (rsp_tdata[351:320] == 32'd0) && (rsp_tdata[383:352] == 32'd0))
      else $error("velocity not zero for non-positive density");
`endif

endmodule
`default_nettype wire
